### src/dsrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrt_pkg: shared types and constants of the date sorted record table
// Holds the word formats, the command and status codes and the state type.
// ----------------------------------------------------------------------------
package dsrt_pkg;

    localparam int Capacity   = 32;
    localparam int MaxResults = 32;
    localparam int IdxW       = $clog2(Capacity);
    localparam int CntW       = $clog2(Capacity + 1);
    localparam int ResW       = $clog2(MaxResults + 1);
    localparam int KeyW       = 23;

    localparam logic [7:0] CharA = 8'h41;
    localparam logic [7:0] Char0 = 8'h30;
    localparam logic [7:0] Char9 = 8'h39;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_SEARCH  = 3'd1,
        CMD_EXTRACT = 3'd2,
        CMD_RANGE   = 3'd3,
        CMD_DUMP    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INVALID   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [39:0] code_text;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  day_end;
        logic [3:0]  month_end;
        logic [13:0] year_end;
        logic [15:0] record_tag;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] code_number;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic [15:0] out_tag;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [13:0] code;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] tag;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_WRITE,
        S_RANGE,
        S_DUMP,
        S_EMIT,
        S_WAIT
    } t_state;

    function automatic logic [KeyW-1:0] entry_key(input t_entry e);
        return {e.year, e.month, e.day};
    endfunction

endpackage

### src/date_sorted_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_sorted_record_table: sorted record table, newest date first
// Insert, search, extract by code, extract by date range and dump, run by a
// sequencer that walks the record RAM one entry per cycle in scan and shifts.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  in      | i_in_valid / o_in_ready     | i_in_word  (t_in_word)
//  out     | o_out_valid / i_out_ready   | o_out_word (t_out_word)
// The code scan reads one entry a cycle, an insert or extract shift moves one
// entry a cycle with a read and a write in the same cycle, and range and dump
// start the read of an entry only once the previous entry has been handled.
// A stalled output holds the sequencer. Reset clears the state, the entry
// count and the output and pending flags; the RAM needs no clearing pass.
module date_sorted_record_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dsrt_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dsrt_pkg::t_out_word  o_out_word
);
    import dsrt_pkg::*;

    t_state          r_state, n_state;
    t_in_word        r_cmd;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_i, n_i;     // read pointer
    logic [CntW-1:0] r_w, n_w;     // write pointer
    logic [CntW-1:0] r_pos, n_pos; // insert position or found index
    logic            r_found, n_found;
    logic            r_rd, n_rd;   // a read is in flight
    logic [ResW-1:0] r_n, n_n;
    logic            r_ovalid, n_ovalid;
    t_out_word       r_oword, n_oword;
    logic            r_pend, n_pend; // a hit waits in r_hold
    t_entry          r_hold, n_hold;

    logic            w_valid;
    logic [13:0]     w_num;
    logic            w_we;
    logic [IdxW-1:0] w_waddr, w_raddr;
    t_entry          w_wdata, w_rdata, w_new;
    logic [KeyW-1:0] w_key, w_lo, w_hi, w_k2, w_rkey;

    dsrt_code_parse u_parse (
        .i_text  (r_cmd.code_text),
        .o_valid (w_valid),
        .o_number(w_num)
    );

    dsrt_entry_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_key  = {r_cmd.year, r_cmd.month, r_cmd.day};
    assign w_k2   = {r_cmd.year_end, r_cmd.month_end, r_cmd.day_end};
    assign w_hi   = (w_key < w_k2) ? w_k2 : w_key;
    assign w_lo   = (w_key < w_k2) ? w_key : w_k2;
    assign w_rkey = entry_key(w_rdata);
    assign w_new  = '{code: w_num, year: r_cmd.year, month: r_cmd.month,
                      day: r_cmd.day, tag: r_cmd.record_tag};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_cmd <= i_in_word;
        r_i     <= n_i;
        r_w     <= n_w;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_rd    <= n_rd;
        r_n     <= n_n;
        r_oword <= n_oword;
        r_hold  <= n_hold;
    end

    function automatic t_out_word mk_out(input t_status s, input t_entry e,
                                         input logic l);
        t_out_word o;
        o.status      = s;
        o.code_number = (s == ST_OK) ? e.code  : '0;
        o.out_day     = (s == ST_OK) ? e.day   : '0;
        o.out_month   = (s == ST_OK) ? e.month : '0;
        o.out_year    = (s == ST_OK) ? e.year  : '0;
        o.out_tag     = (s == ST_OK) ? e.tag   : '0;
        o.last        = l;
        return o;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_w      = r_w;
        n_pos    = r_pos;
        n_found  = r_found;
        n_rd     = 1'b0;
        n_n      = r_n;
        n_ovalid = r_ovalid;
        n_oword  = r_oword;
        n_pend   = r_pend;
        n_hold   = r_hold;
        w_we     = 1'b0;
        w_waddr  = r_w[IdxW-1:0];
        w_wdata  = w_rdata;
        w_raddr  = r_i[IdxW-1:0];
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_i = '0; n_w = '0; n_n = '0; n_found = 1'b0;
                    n_pos = '0; n_pend = 1'b0;
                    priority if (i_in_word.cmd == CMD_RANGE) n_state = S_RANGE;
                    else if (i_in_word.cmd == CMD_DUMP) n_state = S_DUMP;
                    else if (i_in_word.cmd <= CMD_EXTRACT) n_state = S_SCAN;
                    else n_state = S_IDLE;
                end
            end
            // Code scan; for insert also find the first older entry.
            S_SCAN: begin
                if (!w_valid) begin
                    n_oword = mk_out(ST_INVALID, w_rdata, 1'b1);
                    n_ovalid = 1'b1; n_state = S_WAIT;
                end else if (r_rd && w_rdata.code == w_num) begin
                    n_found = 1'b1; n_pos = r_w; n_hold = w_rdata;
                    n_state = S_DECIDE;
                end else begin
                    if (r_rd) begin
                        if (w_rkey >= w_key && r_pos == r_w) n_pos = r_w + 1'b1;
                        n_w = r_w + 1'b1;
                    end
                    if (r_i < r_count) begin
                        n_rd = 1'b1; n_i = r_i + 1'b1;
                    end else n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (r_cmd.cmd == CMD_INSERT) begin
                    priority if (r_found) begin
                        n_oword = mk_out(ST_DUPLICATE, w_rdata, 1'b1);
                        n_ovalid = 1'b1; n_state = S_WAIT;
                    end else if (r_count >= CntW'(Capacity)) begin
                        n_oword = mk_out(ST_FULL, w_rdata, 1'b1);
                        n_ovalid = 1'b1; n_state = S_WAIT;
                    end else begin
                        // Shift from the top down to the insert position.
                        n_i = r_count; n_state = S_SHIFT_UP;
                    end
                end else if (!r_found) begin
                    n_oword = mk_out(ST_NOT_FOUND, w_rdata, 1'b1);
                    n_ovalid = 1'b1; n_state = S_WAIT;
                end else begin
                    n_oword = mk_out(ST_OK, r_hold, 1'b1);
                    n_ovalid = 1'b1;
                    if (r_cmd.cmd == CMD_EXTRACT) begin
                        n_w = r_pos; n_i = r_pos + 1'b1;
                        n_state = S_SHIFT_DOWN;
                    end else n_state = S_WAIT;
                end
            end
            S_SHIFT_UP: begin
                if (r_rd) begin
                    w_we = 1'b1; w_waddr = r_i[IdxW-1:0];
                    n_i = r_i - 1'b1;
                end
                if (n_i > r_pos) begin
                    w_raddr = IdxW'(n_i - 1'b1);
                    n_rd = 1'b1;
                end else n_state = S_WRITE;
            end
            S_WRITE: begin
                w_we = 1'b1; w_waddr = r_pos[IdxW-1:0]; w_wdata = w_new;
                n_count = r_count + 1'b1;
                n_oword = mk_out(ST_OK, w_new, 1'b1);
                n_ovalid = 1'b1; n_state = S_WAIT;
            end
            S_SHIFT_DOWN: begin
                if (r_rd) begin
                    w_we = 1'b1; w_waddr = r_w[IdxW-1:0]; w_wdata = w_rdata;
                    n_w = r_w + 1'b1;
                end
                if (r_i < r_count) begin
                    n_rd = 1'b1; n_i = r_i + 1'b1;
                end else if (!r_rd) begin
                    n_count = r_count - 1'b1; n_state = S_WAIT;
                end
            end
            // Range: compact the table while reporting hits. A hit waits in
            // r_hold until the next hit or the end shows whether it is final.
            // A read is only started when the output will be free for the
            // held word by the time the entry arrives.
            S_RANGE: begin
                if (r_rd) begin
                    if (w_rkey >= w_lo && w_rkey <= w_hi &&
                            r_n < ResW'(MaxResults)) begin
                        if (r_pend) begin
                            n_oword = mk_out(ST_OK, r_hold, 1'b0);
                            n_ovalid = 1'b1;
                        end
                        n_hold = w_rdata; n_pend = 1'b1; n_n = r_n + 1'b1;
                    end else begin
                        w_we = 1'b1; w_waddr = r_w[IdxW-1:0];
                        n_w = r_w + 1'b1;
                    end
                end else if (r_i < r_count) begin
                    if (!r_pend || !r_ovalid || i_out_ready) begin
                        n_rd = 1'b1; n_i = r_i + 1'b1;
                    end
                end else begin
                    n_count = r_w; n_state = S_EMIT;
                end
            end
            S_DUMP: begin
                if (r_rd) begin
                    if (r_pend) begin
                        n_oword = mk_out(ST_OK, r_hold, 1'b0);
                        n_ovalid = 1'b1;
                    end
                    n_hold = w_rdata; n_pend = 1'b1; n_n = r_n + 1'b1;
                end else if (r_i < r_count && r_n < ResW'(MaxResults)) begin
                    if (!r_pend || !r_ovalid || i_out_ready) begin
                        n_rd = 1'b1; n_i = r_i + 1'b1;
                    end
                end else n_state = S_EMIT;
            end
            // Send the held hit as the final word, or not found if none.
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    if (r_pend) n_oword = mk_out(ST_OK, r_hold, 1'b1);
                    else n_oword = mk_out(ST_NOT_FOUND, r_hold, 1'b1);
                    n_ovalid = 1'b1; n_pend = 1'b0; n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/dsrt_code_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrt_code_parse: code text checker
// Checks for 'A' plus four digits and forms the four-digit code number.
// ----------------------------------------------------------------------------
module dsrt_code_parse (
    input  logic [39:0] i_text,
    output logic        o_valid,
    output logic [13:0] o_number
);
    import dsrt_pkg::*;

    logic [3:0] w_dig [4];
    logic       w_ok;

    always_comb begin
        w_ok = (i_text[39:32] == CharA);
        for (int i = 0; i < 4; i++) begin
            logic [7:0] b;
            b = i_text[8*(3-i) +: 8];
            if (b < Char0 || b > Char9) w_ok = 1'b0;
            w_dig[i] = 4'(b - Char0);
        end
        o_valid  = w_ok;
        // Weighted digit sum with constant multipliers.
        o_number = 14'(w_dig[0]) * 14'd1000 + 14'(w_dig[1]) * 14'd100
                 + 14'(w_dig[2]) * 14'd10 + 14'(w_dig[3]);
    end

endmodule

### src/dsrt_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrt_entry_ram: record store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module dsrt_entry_ram (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [dsrt_pkg::IdxW-1:0] i_waddr,
    input  dsrt_pkg::t_entry       i_wdata,
    input  logic [dsrt_pkg::IdxW-1:0] i_raddr,
    output dsrt_pkg::t_entry       o_rdata
);
    import dsrt_pkg::*;

    t_entry r_mem [Capacity];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the date sorted record table
// Drives insert, search, extract, range and dump commands through the input
// handshake, predicts each result word with its own table model and compares
// every received word field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import dsrt_pkg::*;

    localparam int CycleLimit = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    date_sorted_record_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Shadow copy of the table, newest date first.
    t_entry    shadow_table[$];
    t_out_word expected_words[$];
    int        error_count;
    int        words_checked;
    int        cmds_sent;
    int        send_idle_pct;
    int        stall_pct;
    int        hold_off_cycles = 0;
    longint    cycle_count = 0;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Timeout at %0t", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_checked <= words_checked + 1;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %p", $time, o_out_word);
                error_count <= error_count + 1;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_word.status !== exp_w.status ||
                    o_out_word.code_number !== exp_w.code_number ||
                    o_out_word.out_day !== exp_w.out_day ||
                    o_out_word.out_month !== exp_w.out_month ||
                    o_out_word.out_year !== exp_w.out_year ||
                    o_out_word.out_tag !== exp_w.out_tag ||
                    o_out_word.last !== exp_w.last) begin
                    $display("%0t: expected %p actual %p", $time, exp_w, o_out_word);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    function automatic logic [22:0] date_of(input t_entry e);
        return {e.year, e.month, e.day};
    endfunction

    function automatic t_out_word report_word(input t_status st, input t_entry e);
        t_out_word w;
        w = '0;
        w.status = st;
        if (st == ST_OK) begin
            w.code_number = e.code;
            w.out_day     = e.day;
            w.out_month   = e.month;
            w.out_year    = e.year;
            w.out_tag     = e.tag;
        end
        return w;
    endfunction

    // Returns 1 and the number when the text reads 'A' and four digits.
    function automatic bit decode_code(input logic [39:0] text, output logic [13:0] num);
        int v;
        logic [7:0] b;
        v = 0;
        num = '0;
        if (text[39:32] != CharA) return 0;
        for (int i = 3; i >= 0; i--) begin
            b = text[8*i +: 8];
            if (b < Char0 || b > Char9) return 0;
            v = v * 10 + (b - Char0);
        end
        num = v[13:0];
        return 1;
    endfunction

    function automatic int find_code(input logic [13:0] num);
        foreach (shadow_table[i])
            if (shadow_table[i].code == num) return i;
        return -1;
    endfunction

    // Works out the result words of one command and updates the shadow table.
    task automatic predict_table(input t_in_word w);
        t_out_word res[$];
        t_entry    e, keep[$];
        logic [13:0] num;
        logic [22:0] key, hi, lo;
        bit ok;
        int idx, pos;
        ok  = decode_code(w.code_text, num);
        key = {w.year, w.month, w.day};
        case (w.cmd)
            CMD_INSERT: begin
                e = '{code: num, year: w.year, month: w.month, day: w.day, tag: w.record_tag};
                if (!ok) res.push_back(report_word(ST_INVALID, e));
                else if (find_code(num) >= 0) res.push_back(report_word(ST_DUPLICATE, e));
                else if (shadow_table.size() >= Capacity) res.push_back(report_word(ST_FULL, e));
                else begin
                    pos = 0;
                    while (pos < shadow_table.size() && date_of(shadow_table[pos]) >= key)
                        pos++;
                    shadow_table.insert(pos, e);
                    res.push_back(report_word(ST_OK, e));
                end
            end
            CMD_SEARCH, CMD_EXTRACT: begin
                idx = ok ? find_code(num) : -1;
                if (!ok) res.push_back(report_word(ST_INVALID, '0));
                else if (idx < 0) res.push_back(report_word(ST_NOT_FOUND, '0));
                else begin
                    res.push_back(report_word(ST_OK, shadow_table[idx]));
                    if (w.cmd == CMD_EXTRACT) shadow_table.delete(idx);
                end
            end
            CMD_RANGE: begin
                hi = key;
                lo = {w.year_end, w.month_end, w.day_end};
                if (hi < lo) begin
                    hi = lo;
                    lo = key;
                end
                foreach (shadow_table[i]) begin
                    if (date_of(shadow_table[i]) >= lo && date_of(shadow_table[i]) <= hi &&
                        res.size() < MaxResults)
                        res.push_back(report_word(ST_OK, shadow_table[i]));
                    else
                        keep.push_back(shadow_table[i]);
                end
                shadow_table = keep;
                if (res.size() == 0) res.push_back(report_word(ST_NOT_FOUND, '0));
            end
            CMD_DUMP: begin
                foreach (shadow_table[i])
                    if (res.size() < MaxResults) res.push_back(report_word(ST_OK, shadow_table[i]));
                if (res.size() == 0) res.push_back(report_word(ST_NOT_FOUND, '0));
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) expected_words.push_back(res[i]);
    endtask

    // Valid stays up after an accept until the next command or an idle cycle
    // replaces it, so each input gets one assignment per clock edge.
    task automatic send_cmd(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
            @(posedge i_clk);
        end
        predict_table(w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cmds_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [39:0] code_text_of(input int n);
        return {CharA, Char0 + 8'(n / 1000), Char0 + 8'(n / 100 % 10),
                Char0 + 8'(n / 10 % 10), Char0 + 8'(n % 10)};
    endfunction

    // Mostly codes from a small pool so that hits, duplicates and removals occur.
    function automatic t_in_word random_cmd();
        t_in_word w;
        int r;
        w = '0;
        r = $urandom_range(99);
        w.cmd = (r < 45) ? CMD_INSERT : (r < 60) ? CMD_SEARCH : (r < 75) ? CMD_EXTRACT :
                (r < 85) ? CMD_RANGE : (r < 93) ? CMD_DUMP : t_cmd'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 85) w.code_text = code_text_of($urandom_range(60));
        else if (r < 92) w.code_text = code_text_of($urandom_range(9999));
        else w.code_text = {$urandom, 8'($urandom)};
        if ($urandom_range(9) == 0) begin
            w.day = 5'($urandom); w.month = 4'($urandom); w.year = 14'($urandom);
        end else begin
            w.day = 5'($urandom_range(31, 1)); w.month = 4'($urandom_range(12, 1));
            w.year = 14'($urandom_range(2030, 1990));
        end
        w.day_end   = 5'($urandom_range(31, 1));
        w.month_end = 4'($urandom_range(12, 1));
        w.year_end  = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(2030, 1990));
        w.record_tag = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_word make_cmd(input t_cmd c, input logic [39:0] text,
                                          input int d, input int m, input int y);
        t_in_word w;
        w = '0;
        w.cmd = c; w.code_text = text;
        w.day = 5'(d); w.month = 4'(m); w.year = 14'(y);
        w.record_tag = 16'($urandom);
        return w;
    endfunction

    task automatic test_directed();
        t_in_word w;
        send_cmd(make_cmd(CMD_DUMP, code_text_of(0), 1, 1, 0));
        send_cmd(make_cmd(CMD_INSERT, code_text_of(0), 1, 1, 0));
        send_cmd(make_cmd(CMD_INSERT, code_text_of(9999), 31, 12, 9999));
        send_cmd(make_cmd(CMD_INSERT, code_text_of(1234), 1, 1, 0));
        send_cmd(make_cmd(CMD_INSERT, code_text_of(9999), 5, 5, 2000));
        send_cmd(make_cmd(CMD_INSERT, {8'h42, 32'h3030_3031}, 1, 1, 1));
        send_cmd(make_cmd(CMD_INSERT, {CharA, 8'h3A, 24'h303030}, 1, 1, 1));
        send_cmd(make_cmd(CMD_INSERT, {CharA, 8'h2F, 24'h303030}, 1, 1, 1));
        send_cmd(make_cmd(CMD_INSERT, code_text_of(42), 31, 15, 16383));
        send_cmd(make_cmd(CMD_SEARCH, code_text_of(1234), 0, 0, 0));
        send_cmd(make_cmd(CMD_SEARCH, code_text_of(7), 0, 0, 0));
        send_cmd(make_cmd(CMD_SEARCH, 40'hFF_FFFF_FFFF, 0, 0, 0));
        send_cmd(make_cmd(CMD_EXTRACT, code_text_of(0), 0, 0, 0));
        send_cmd(make_cmd(CMD_EXTRACT, code_text_of(0), 0, 0, 0));
        send_cmd(make_cmd(CMD_EXTRACT, 40'h0, 0, 0, 0));
        send_cmd(make_cmd(CMD_DUMP, 40'h0, 0, 0, 0));
        w = make_cmd(CMD_RANGE, 40'h0, 1, 1, 0);
        w.day_end = 5'd31; w.month_end = 4'd12; w.year_end = 14'd9999;
        send_cmd(w);
        send_cmd(make_cmd(CMD_RANGE, 40'h0, 1, 1, 0));
        send_cmd(make_cmd(t_cmd'(3'd5), 40'h0, 0, 0, 0));
        send_cmd(make_cmd(t_cmd'(3'd7), 40'h0, 0, 0, 0));
        // Fill the table past capacity, then take it apart with one wide range.
        for (int i = 0; i <= Capacity; i++)
            send_cmd(make_cmd(CMD_INSERT, code_text_of(100 + i), $urandom_range(31, 1),
                              $urandom_range(12, 1), $urandom_range(2000, 1990)));
        send_cmd(make_cmd(CMD_DUMP, 40'h0, 0, 0, 0));
        w = make_cmd(CMD_RANGE, 40'h0, 31, 15, 16383);
        send_cmd(w);
        wait_drained();
    endtask

    task automatic test_random(input int n_cmds, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < n_cmds; i++) send_cmd(random_cmd());
        wait_drained();
    endtask

    // Hold the receiver off while dumps pile up so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int i = 0; i < 12; i++)
            send_cmd(make_cmd(CMD_INSERT, code_text_of(500 + i), $urandom_range(31, 1),
                              $urandom_range(12, 1), $urandom_range(2030, 1990)));
        wait_drained();
        hold_off_cycles <= 400;
        for (int i = 0; i < 4; i++) send_cmd(make_cmd(CMD_DUMP, 40'h0, 0, 0, 0));
        wait_drained();
    endtask

    initial begin
        error_count = 0; words_checked = 0; cmds_sent = 0;
        send_idle_pct = 0; stall_pct = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(45, 0, 0);
        test_random(45, 46, 0);
        test_random(45, 0, 46);
        test_random(45, 9, 9);
        test_backpressure();
        $display("Covered %0d commands and %0d result words over all opcodes,", cmds_sent,
                 words_checked);
        $display("full and empty table, and idle, stall and long hold-off patterns.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
